### rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants and types for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int MAX_BUFFER  = 64;
  localparam int STORE_DEPTH = MAX_BUFFER - 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int SIZE_W      = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE = 1'd1;

  localparam logic [SIZE_W-1:0] BUFFER_SIZE_RST = SIZE_W'(MAX_BUFFER);

  localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } sle_res_t;

  typedef struct packed {
    logic [FILL_W-1:0] room;
    logic              echo;
  } sle_cfg_t;

endpackage

### rtl/core/sle_if.sv
// ----------------------------------------------------------------------------
// sle_rx_if / sle_res_if
// Valid/ready channels for received bytes and editor results.
// ----------------------------------------------------------------------------
interface sle_rx_if;
  import sle_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_res_if;
  import sle_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/core/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Byte decoder and line sequencer: edits the line store, drains it at
// line end and pushes results into the output queue.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [sle_pkg::BYTE_W-1:0]    in_byte,
  output logic                          in_ready,
  input  sle_pkg::sle_cfg_t             cfg,
  input  logic                          push_ok,
  output logic                          push,
  output sle_pkg::sle_res_t             res,
  output logic                          ram_we,
  output logic [sle_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [sle_pkg::BYTE_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [sle_pkg::ADDR_W-1:0]    ram_raddr,
  input  logic [sle_pkg::BYTE_W-1:0]    ram_rdata
);
  import sle_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic              state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;

  logic accept;
  logic is_eol, is_bs, is_esc, is_prt;
  logic push_char, issue, drained;

  assign in_ready = (state_r == ST_IDLE) && push_ok;
  assign accept   = in_valid && in_ready;

  assign is_eol = (in_byte == CH_LF) || (in_byte == CH_CR);
  assign is_bs  = (in_byte == CH_BS) || (in_byte == CH_DEL);
  assign is_esc = (in_byte == CH_ESC);
  assign is_prt = (in_byte >= CH_SPACE) && (in_byte <= CH_TILDE);

  assign push_char = pend_r && push_ok;
  assign issue     = (rd_idx_r < fill_r) && (!pend_r || push_char);
  assign drained   = !pend_r && (rd_idx_r == fill_r);

  assign ram_waddr = fill_r[ADDR_W-1:0];
  assign ram_wdata = in_byte;
  assign ram_raddr = rd_idx_r[ADDR_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt   = pend_r;
    push       = 1'b0;
    res        = '{kind: KIND_ECHO, data: in_byte, last: 1'b1};
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_eol) begin
            push       = cfg.echo;
            res        = '{kind: KIND_ECHO, data: CH_LF, last: 1'b0};
            rd_idx_nxt = '0;
            pend_nxt   = 1'b0;
            state_nxt  = ST_FLUSH;
          end else if (is_bs) begin
            if (fill_r != '0) begin
              fill_nxt = fill_r - FILL_W'(1);
              push     = cfg.echo;
            end
          end else if (is_esc) begin
            fill_nxt = '0;
            push     = 1'b1;
            res      = '{kind: KIND_CANCEL, data: CH_NUL, last: 1'b1};
          end else if (is_prt) begin
            push = cfg.echo;
            if (fill_r < cfg.room) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end
          end
        end
      end
      ST_FLUSH: begin
        ram_re = issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + FILL_W'(1);
        end
        pend_nxt = issue || (pend_r && !push_char);
        if (push_char) begin
          push = 1'b1;
          res  = '{kind: KIND_CHAR, data: ram_rdata, last: 1'b0};
        end else if (drained && push_ok) begin
          push      = 1'b1;
          res       = '{kind: KIND_CHAR, data: CH_LF, last: 1'b1};
          fill_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rd_idx_r <= rd_idx_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

### rtl/core/serial_line_editor.sv
// ----------------------------------------------------------------------------
// serial_line_editor
// Line editor for received serial bytes with optional terminal echo.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per transaction; out_ch carries results
//   (kind, out_byte, last). cfg_we/cfg_index/cfg_data write buffer_size
//   (index 0) and echo_enable (index 1); the user is to write them only
//   while the block is idle, as the block itself does not enforce this.
//   Editing bytes (printable, backspace, DEL, escape) give at most one
//   result, held in the output queue from the cycle after the input
//   transaction. A line end switches to a flush that reads the line RAM
//   once per stored character: a first RAM read, then one result per cycle
//   while the output queue has room. The echo (if on) is queued by the line
//   end transaction itself, and a newline marked last closes the flush.
//   The output side is a two-entry queue: a new byte is taken while one
//   result still waits; with both entries full and none leaving, or during
//   a flush, in_ch ready is low. Receiver stalls hold the flush in place.
//   Reset (rst_n low, synchronous) empties the line and the queue, sets
//   buffer_size to 64 and echo off. The line RAM is not cleared; only
//   written entries are ever read.
// ----------------------------------------------------------------------------
module serial_line_editor (
  input  logic                              clk,
  input  logic                              rst_n,
  sle_rx_if.sink                            in_ch,
  sle_res_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [sle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sle_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sle_pkg::*;

  logic [SIZE_W-1:0] buf_size_r;
  logic              echo_r;
  sle_cfg_t          cfg;

  sle_res_t          q_r [2];
  logic              wptr_r, rptr_r;
  logic [1:0]        cnt_r, cnt_nxt;

  logic              push, pop, push_ok;
  sle_res_t          res;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUFFER_SIZE_RST;
      echo_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUFFER_SIZE: buf_size_r <= cfg_data;
        CFG_ECHO_ENABLE: echo_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (buf_size_r > SIZE_W'(MAX_BUFFER)) begin
      cfg.room = FILL_W'(STORE_DEPTH);
    end else if (buf_size_r < SIZE_W'(2)) begin
      cfg.room = '0;
    end else begin
      cfg.room = FILL_W'(buf_size_r - SIZE_W'(2));
    end
    cfg.echo = echo_r;
  end

  assign pop     = out_ch.valid && out_ch.ready;
  assign push_ok = (cnt_r != 2'd2) || pop;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= res;
    end
  end

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.kind     = q_r[rptr_r].kind;
  assign out_ch.out_byte = q_r[rptr_r].data;
  assign out_ch.last     = q_r[rptr_r].last;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ch.ready),
    .cfg       (cfg),
    .push_ok   (push_ok),
    .push      (push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/core/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the serial line editor, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [sle_pkg::BYTE_W-1:0]    in_byte,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sle_pkg::KIND_W-1:0]    kind,
  input logic [sle_pkg::BYTE_W-1:0]    out_byte,
  input logic                          last
);
  import sle_pkg::*;

  a_cancel_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_CANCEL) |-> last && (out_byte == CH_NUL))
    else $error("cancel result malformed");

  a_echo_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_ECHO) && !last |-> (out_byte == CH_LF))
    else $error("non-final echo is not a line-end newline");

  a_esc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_byte == CH_ESC) |=> out_valid)
    else $error("escape transaction gave no result");

  a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_byte == CH_LF) || (in_byte == CH_CR)) |=> !in_ready)
    else $error("input taken during line flush");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_byte   (in_ch.rx_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .out_byte  (out_ch.out_byte),
  .last      (out_ch.last)
);
